// ===== rtl/ucbt_pkg.sv =====
// ----------------------------------------------------------------------------
// ucbt_pkg
// shared widths, controller states and the command word for the tessellator
// ----------------------------------------------------------------------------
package ucbt_pkg;

  localparam int unsigned COORD_W   = 16;
  localparam int unsigned STEPS_W   = 7;
  localparam int unsigned MAX_STEPS = 64;
  localparam int unsigned B_W       = 20;  // six times a bezier control
  localparam int unsigned SQ_W      = 13;  // squares of counts up to 64
  localparam int unsigned W_W       = 20;  // bernstein weights times n^3
  localparam int unsigned D_W       = 21;  // 6 n^3
  localparam int unsigned ACC_W     = 42;
  localparam int unsigned NUM_W     = 40;
  localparam int unsigned Q_W       = 16;
  localparam int unsigned DIV_STEPS = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP_N,
    ST_PREP_D,
    ST_WT1,
    ST_WT2,
    ST_MAC,
    ST_DIV_INIT,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic               load_in;
    logic               restart;
    logic               push_in;
    logic               prep_n;
    logic               prep_d;
    logic               wt1;
    logic               wt2;
    logic               mac;
    logic               div_init;
    logic               div_step;
    logic               emit;
    logic               push_p3;
    logic               seg_end;
    logic [1:0]         term;
    logic [STEPS_W-1:0] k;
    logic [STEPS_W-1:0] n;
  } cmd_t;

endpackage

// ===== rtl/ucbt_ctrl.sv =====
// ----------------------------------------------------------------------------
// ucbt_ctrl
// sequencer: window fill, per-point weight, mac and divide steps, output slot
// ----------------------------------------------------------------------------
module ucbt_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        first_point_i,
  input  logic                        cfg_we_i,
  input  logic [ucbt_pkg::STEPS_W-1:0] cfg_wdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output ucbt_pkg::cmd_t              cmd_o
);
  import ucbt_pkg::*;

  state_e             state_q, state_d;
  logic [1:0]         seen_q;
  logic [STEPS_W-1:0] steps_q, k_q, n_eff;
  logic [1:0]         term_q;
  logic [3:0]         step_q;
  logic               out_valid_q;
  logic               in_acc, slot_free, last_k;

  always_comb begin
    if (steps_q == '0) begin
      n_eff = STEPS_W'(1);
    end else if (steps_q > STEPS_W'(MAX_STEPS)) begin
      n_eff = STEPS_W'(MAX_STEPS);
    end else begin
      n_eff = steps_q;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;
  assign slot_free   = ~out_valid_q | out_ready_i;
  assign last_k      = (k_q == n_eff - STEPS_W'(1));
  assign out_valid_o = out_valid_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !first_point_i && seen_q == 2'd3) state_d = ST_PREP_N;
      end
      ST_PREP_N:   state_d = ST_PREP_D;
      ST_PREP_D:   state_d = ST_WT1;
      ST_WT1:      state_d = ST_WT2;
      ST_WT2:      state_d = ST_MAC;
      ST_MAC: begin
        if (term_q == 2'd3) state_d = ST_DIV_INIT;
      end
      ST_DIV_INIT: state_d = ST_DIV;
      ST_DIV: begin
        if (step_q == 4'(DIV_STEPS - 1)) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) state_d = last_k ? ST_IDLE : ST_WT1;
      end
      default:     state_d = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o          = '0;
    cmd_o.k        = k_q;
    cmd_o.n        = n_eff;
    cmd_o.term     = term_q;
    cmd_o.seg_end  = last_k;
    cmd_o.load_in  = in_acc;
    cmd_o.restart  = in_acc & first_point_i;
    cmd_o.push_in  = in_acc & ~first_point_i & (seen_q != 2'd3);
    cmd_o.prep_n   = (state_q == ST_PREP_N);
    cmd_o.prep_d   = (state_q == ST_PREP_D);
    cmd_o.wt1      = (state_q == ST_WT1);
    cmd_o.wt2      = (state_q == ST_WT2);
    cmd_o.mac      = (state_q == ST_MAC);
    cmd_o.div_init = (state_q == ST_DIV_INIT);
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.emit     = (state_q == ST_EMIT) & slot_free;
    cmd_o.push_p3  = (state_q == ST_EMIT) & slot_free & last_k;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      seen_q      <= '0;
      steps_q     <= STEPS_W'(MAX_STEPS);
      k_q         <= '0;
      term_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) steps_q <= cfg_wdata_i;
      if (in_acc) begin
        if (first_point_i) begin
          seen_q <= 2'd1;
        end else if (seen_q != 2'd3) begin
          seen_q <= seen_q + 2'd1;
        end
        k_q <= '0;
      end
      if (state_q == ST_WT2) term_q <= '0;
      if (state_q == ST_MAC) term_q <= term_q + 2'd1;
      if (state_q == ST_DIV_INIT) step_q <= '0;
      if (state_q == ST_DIV) step_q <= step_q + 4'd1;
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
        k_q         <= k_q + STEPS_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/ucbt_datapath.sv =====
// ----------------------------------------------------------------------------
// ucbt_datapath
// control point window, bezier controls, weight and mac unit, two dividers
// ----------------------------------------------------------------------------
module ucbt_datapath (
  input  logic                               clk_i,
  input  ucbt_pkg::cmd_t                     cmd_i,
  input  logic signed [ucbt_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [ucbt_pkg::COORD_W-1:0] point_y_i,
  output logic signed [ucbt_pkg::COORD_W-1:0] curve_x_o,
  output logic signed [ucbt_pkg::COORD_W-1:0] curve_y_o,
  output logic                               segment_end_o
);
  import ucbt_pkg::*;

  logic signed [COORD_W-1:0] win_x_q [3];
  logic signed [COORD_W-1:0] win_y_q [3];
  logic signed [COORD_W-1:0] p3x_q, p3y_q;
  logic signed [B_W-1:0]     bx_q [4];
  logic signed [B_W-1:0]     by_q [4];
  logic [SQ_W-1:0]           n2_q, a2_q, ak_q, k2_q;
  logic [D_W-1:0]            d_q;
  logic [W_W-1:0]            w_q [4];
  logic signed [ACC_W-1:0]   accx_q, accy_q;
  logic [NUM_W-1:0]          remx_q, remy_q, dsh_q;
  logic [Q_W-1:0]            qx_q, qy_q;
  logic signed [COORD_W-1:0] cx_q, cy_q;
  logic                      end_q;

  logic [STEPS_W-1:0]        a;
  logic [2*STEPS_W-1:0]      a2p, akp, k2p, n2p;
  logic [SQ_W+STEPS_W-1:0]   m0, m1, m2, m3, nd;
  logic signed [W_W:0]       w_s;
  logic signed [B_W+W_W:0]   px, py;
  logic signed [ACC_W+1:0]   numx, numy, dext;
  logic [NUM_W-1:0]          subx, suby;

  function automatic logic signed [B_W-1:0] sx(input logic signed [COORD_W-1:0] v);
    return B_W'(v);
  endfunction

  assign a   = cmd_i.n - cmd_i.k;
  assign a2p = a * a;
  assign akp = a * cmd_i.k;
  assign k2p = cmd_i.k * cmd_i.k;
  assign n2p = cmd_i.n * cmd_i.n;
  assign m0  = a2_q * a;
  assign m1  = a2_q * cmd_i.k;
  assign m2  = ak_q * cmd_i.k;
  assign m3  = k2_q * cmd_i.k;
  assign nd  = n2_q * cmd_i.n;
  assign w_s = $signed({1'b0, w_q[cmd_i.term]});
  assign px  = w_s * bx_q[cmd_i.term];
  assign py  = w_s * by_q[cmd_i.term];
  // offset numerator so the floor division runs unsigned
  assign dext = $signed({{(ACC_W+2-D_W){1'b0}}, d_q});
  assign numx = (ACC_W+2)'(accx_q) * 2 + dext + (dext <<< 16);
  assign numy = (ACC_W+2)'(accy_q) * 2 + dext + (dext <<< 16);
  assign subx = remx_q - dsh_q;
  assign suby = remy_q - dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      p3x_q <= point_x_i;
      p3y_q <= point_y_i;
    end
    if (cmd_i.restart) begin
      win_x_q[0] <= '0;        win_y_q[0] <= '0;
      win_x_q[1] <= '0;        win_y_q[1] <= '0;
      win_x_q[2] <= point_x_i; win_y_q[2] <= point_y_i;
    end else if (cmd_i.push_in) begin
      win_x_q[0] <= win_x_q[1]; win_y_q[0] <= win_y_q[1];
      win_x_q[1] <= win_x_q[2]; win_y_q[1] <= win_y_q[2];
      win_x_q[2] <= point_x_i;  win_y_q[2] <= point_y_i;
    end else if (cmd_i.push_p3) begin
      win_x_q[0] <= win_x_q[1]; win_y_q[0] <= win_y_q[1];
      win_x_q[1] <= win_x_q[2]; win_y_q[1] <= win_y_q[2];
      win_x_q[2] <= p3x_q;      win_y_q[2] <= p3y_q;
    end
    if (cmd_i.prep_n) begin
      n2_q  <= n2p[SQ_W-1:0];
      bx_q[0] <= sx(win_x_q[0]) + (sx(win_x_q[1]) <<< 2) + sx(win_x_q[2]);
      bx_q[1] <= (sx(win_x_q[1]) <<< 2) + (sx(win_x_q[2]) <<< 1);
      bx_q[2] <= (sx(win_x_q[1]) <<< 1) + (sx(win_x_q[2]) <<< 2);
      bx_q[3] <= sx(win_x_q[1]) + (sx(win_x_q[2]) <<< 2) + sx(p3x_q);
      by_q[0] <= sx(win_y_q[0]) + (sx(win_y_q[1]) <<< 2) + sx(win_y_q[2]);
      by_q[1] <= (sx(win_y_q[1]) <<< 2) + (sx(win_y_q[2]) <<< 1);
      by_q[2] <= (sx(win_y_q[1]) <<< 1) + (sx(win_y_q[2]) <<< 2);
      by_q[3] <= sx(win_y_q[1]) + (sx(win_y_q[2]) <<< 2) + sx(p3y_q);
    end
    if (cmd_i.prep_d) d_q <= (D_W'(nd) << 2) + (D_W'(nd) << 1);
    if (cmd_i.wt1) begin
      a2_q <= a2p[SQ_W-1:0];
      ak_q <= akp[SQ_W-1:0];
      k2_q <= k2p[SQ_W-1:0];
    end
    if (cmd_i.wt2) begin
      w_q[0] <= W_W'(m0);
      w_q[1] <= W_W'((m1 << 1) + m1);
      w_q[2] <= W_W'((m2 << 1) + m2);
      w_q[3] <= W_W'(m3);
      accx_q <= '0;
      accy_q <= '0;
    end
    if (cmd_i.mac) begin
      accx_q <= accx_q + ACC_W'(px);
      accy_q <= accy_q + ACC_W'(py);
    end
    if (cmd_i.div_init) begin
      remx_q <= numx[NUM_W-1:0];
      remy_q <= numy[NUM_W-1:0];
      dsh_q  <= NUM_W'({d_q, 16'b0});
      qx_q   <= '0;
      qy_q   <= '0;
    end
    if (cmd_i.div_step) begin
      if (remx_q >= dsh_q) begin
        remx_q <= subx;
        qx_q   <= {qx_q[Q_W-2:0], 1'b1};
      end else begin
        qx_q   <= {qx_q[Q_W-2:0], 1'b0};
      end
      if (remy_q >= dsh_q) begin
        remy_q <= suby;
        qy_q   <= {qy_q[Q_W-2:0], 1'b1};
      end else begin
        qy_q   <= {qy_q[Q_W-2:0], 1'b0};
      end
      dsh_q <= dsh_q >> 1;
    end
    if (cmd_i.emit) begin
      cx_q  <= $signed({~qx_q[Q_W-1], qx_q[Q_W-2:0]});
      cy_q  <= $signed({~qy_q[Q_W-1], qy_q[Q_W-2:0]});
      end_q <= cmd_i.seg_end;
    end
  end

  assign curve_x_o     = cx_q;
  assign curve_y_o     = cy_q;
  assign segment_end_o = end_q;

endmodule

// ===== rtl/uniform_cubic_bspline_tessellator_core.sv =====
// ----------------------------------------------------------------------------
// uniform_cubic_bspline_tessellator_core
// uniform cubic b-spline to curve points, one segment per control point
// ----------------------------------------------------------------------------
// Control points come in one word at a time; first_point_i starts a new curve.
// The first three points of a curve are only stored and leave the input ready.
// Every later point closes a segment and produces N curve points (N from the
// steps register, 0 read as 1, above 64 read as 64), the last one flagged with
// segment_end_o. A segment opens by preparing the bezier controls, then 6 N^3.
// Each curve point then takes two weight steps, four mac steps (one per term,
// one multiplier per axis), one divider load, sixteen steps of the restoring
// divider that divides by 6 N^3 with round to nearest, and one output slot,
// which waits while the output side stalls. The input is not ready while a
// segment is worked on. The result sits in an output register, so the next
// control point is taken while the last curve point still waits.
// ----------------------------------------------------------------------------
module uniform_cubic_bspline_tessellator_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [ucbt_pkg::COORD_W-1:0] point_x_i,
  input  logic signed [ucbt_pkg::COORD_W-1:0] point_y_i,
  input  logic                                first_point_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [ucbt_pkg::COORD_W-1:0] curve_x_o,
  output logic signed [ucbt_pkg::COORD_W-1:0] curve_y_o,
  output logic                                segment_end_o,
  input  logic                                cfg_we_i,
  input  logic [ucbt_pkg::STEPS_W-1:0]        cfg_wdata_i
);
  import ucbt_pkg::*;

  cmd_t cmd;

  // sequencer owns the point count, the steps register and the output valid
  ucbt_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .first_point_i(first_point_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  // window, arithmetic and output word
  ucbt_datapath u_dp (
    .clk_i        (clk_i),
    .cmd_i        (cmd),
    .point_x_i    (point_x_i),
    .point_y_i    (point_y_i),
    .curve_x_o    (curve_x_o),
    .curve_y_o    (curve_y_o),
    .segment_end_o(segment_end_o)
  );

endmodule

// ===== rtl/ucbt_checker.sv =====
// ----------------------------------------------------------------------------
// ucbt_checker
// port level checks on the tessellator, bound to the top level
// ----------------------------------------------------------------------------
module ucbt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        first_point_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [15:0] curve_x_o
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(curve_x_o))
    else $error("output word dropped or changed while stalled");

  // taking a control point never touches the output word in the same cycle
  a_out_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && out_valid_o |=> $stable(curve_x_o))
    else $error("output word changed on a control point take");

  // a curve start only stores the point
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && first_point_i |=> in_ready_o)
    else $error("start point did not leave the block ready");

  // nothing valid during reset
  a_reset: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("output valid during reset");

endmodule

bind uniform_cubic_bspline_tessellator_core ucbt_checker u_ucbt_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .first_point_i(first_point_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .curve_x_o    (curve_x_o)
);
